[sv/fbfla_pkg.sv]
// ----------------------------------------------------------------------------
// fbfla_pkg: shared types and constants for the fixed block pool allocator
// Status codes, register map, reset values and field widths.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  // Default pool depth
  localparam int unsigned POOL_BLOCKS_DEF = 256;

  // Field widths
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned ALIGN_W  = 13;
  localparam int unsigned FIDX_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIVE_W   = 9;
  localparam int unsigned BYTES_W  = 24;
  localparam int unsigned STRIDE_W = 17;

  // Configuration port
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 5;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_POOL_BASE   = 2'd0;
  localparam reg_idx_t REG_BLOCK_BYTES = 2'd1;
  localparam reg_idx_t REG_BLOCK_ALIGN = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0]  BLOCK_BYTES_RST = 16'd16;
  localparam logic [ALIGN_W-1:0] BLOCK_ALIGN_RST = 13'd8;

  // Live count saturates here
  localparam logic [LIVE_W-1:0] LIVE_MAX = 9'd511;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_SIZE_ERR    = 3'd1;
  localparam status_t ST_ALIGN_ERR   = 3'd2;
  localparam status_t ST_POOL_EMPTY  = 3'd3;
  localparam status_t ST_NONE_LIVE   = 3'd4;

endpackage

[sv/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator: pool of equal blocks on a linked free list
// Allocate pops the list head and returns its index and byte address; free
// pushes an index back. Links live in a one-read, one-write synchronous RAM.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  request  | start / busy               | in_kind, in_req_size, in_req_align,
//           |                            | in_free_index
//  result   | out_valid (1-cycle strobe) | out_status, out_block_index,
//           |                            | out_block_address, out_live_count,
//           |                            | out_bytes_in_use
//  config   | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// A successful allocate goes through the link RAM read, then the stride
// multiply, then the address add before its result transfers; frees and
// rejected requests skip the multiply. busy falls as the result strobe rises,
// so the next request can be taken at the edge that takes the result.
// After reset the link RAM is loaded with the initial chain, one entry per
// cycle, with busy high throughout. Config writes are taken always.
// The result is driven for one cycle only; the receiver cannot stall it.

module fixed_block_free_list_allocator
  import fbfla_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [SIZE_W-1:0]     in_req_size,
  input  logic [ALIGN_W-1:0]    in_req_align,
  input  logic [FIDX_W-1:0]     in_free_index,
  // result channel
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [FIDX_W-1:0]     out_block_index,
  output logic [ADDR_W-1:0]     out_block_address,
  output logic [LIVE_W-1:0]     out_live_count,
  output logic [BYTES_W-1:0]    out_bytes_in_use,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Index width and link width (link holds null = POOL_BLOCKS)
  localparam int unsigned IW   = $clog2(POOL_BLOCKS);
  localparam int unsigned LW   = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned PW   = IW + STRIDE_W;
  localparam int unsigned BW   = SIZE_W + LIVE_W;
  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_BLOCKS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_BLOCKS - 1);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_LINK,
    S_CALC
  } state_t;

  state_t               state_r;
  logic [IW-1:0]        init_cnt_r;
  logic [LW-1:0]        head_r;
  logic [LIVE_W-1:0]    live_r;
  logic [IW-1:0]        idx_r;
  logic                 alloc_ok_r;
  status_t              status_r;
  logic [PW-1:0]        prod_r;

  logic [ADDR_W-1:0]    pool_base_r;
  logic [SIZE_W-1:0]    block_bytes_r;
  logic [ALIGN_W-1:0]   block_align_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [FIDX_W-1:0]    out_index_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [LIVE_W-1:0]    out_live_r;
  logic [BYTES_W-1:0]   out_bytes_r;

  // Link RAM
  logic [LW-1:0]        link_mem [POOL_BLOCKS];
  logic [LW-1:0]        link_rdata;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [LW-1:0]        mem_wdata;

  logic                 accept;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic                 fidx_in_range;
  logic                 free_push;
  status_t              req_status;
  logic [STRIDE_W-1:0]  stride;
  logic [BW-1:0]        bytes_full;

  assign accept        = start && (state_r == S_IDLE);
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign cfg_idx       = paddr[APB_ADDR_W-1:3];
  assign fidx_in_range = 32'(in_free_index) < POOL_BLOCKS;
  assign stride        = STRIDE_W'(block_bytes_r) + STRIDE_W'(block_align_r);
  assign bytes_full    = BW'(live_r) * BW'(block_bytes_r);

  // Status of the request at accept; checks in priority order
  always_comb begin
    req_status = ST_OK;
    if (in_kind == KIND_ALLOC) begin
      if (in_req_size != block_bytes_r) begin
        req_status = ST_SIZE_ERR;
      end else if (in_req_align != block_align_r) begin
        req_status = ST_ALIGN_ERR;
      end else if (head_r == LINK_NULL) begin
        req_status = ST_POOL_EMPTY;
      end
    end else if (live_r == '0) begin
      req_status = ST_NONE_LIVE;
    end
  end

  assign free_push = accept && (in_kind == KIND_FREE) && (live_r != '0) && fidx_in_range;

  // RAM write port: initial chain load, or link of a freed block
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = init_cnt_r;
    mem_wdata = LW'(init_cnt_r) + LW'(1);
    if (state_r == S_INIT) begin
      mem_we = 1'b1;
    end else if (free_push) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(in_free_index);
      mem_wdata = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rdata <= link_mem[head_r[IW-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      block_bytes_r <= BLOCK_BYTES_RST;
      block_align_r <= BLOCK_ALIGN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POOL_BASE:   pool_base_r   <= pwdata[ADDR_W-1:0];
        REG_BLOCK_BYTES: block_bytes_r <= pwdata[SIZE_W-1:0];
        REG_BLOCK_ALIGN: block_align_r <= pwdata[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_POOL_BASE:   prdata = APB_DATA_W'(pool_base_r);
      REG_BLOCK_BYTES: prdata = APB_DATA_W'(block_bytes_r);
      REG_BLOCK_ALIGN: prdata = APB_DATA_W'(block_align_r);
      default:         prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Sequencer, list state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      head_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_CALC);
      case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + IW'(1);
          if (init_cnt_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            status_r   <= req_status;
            prod_r     <= '0;
            idx_r      <= head_r[IW-1:0];
            if (in_kind == KIND_ALLOC && req_status == ST_OK) begin
              alloc_ok_r <= 1'b1;
              state_r    <= S_LINK;
            end else begin
              alloc_ok_r <= 1'b0;
              state_r    <= S_CALC;
            end
            if (free_push) begin
              head_r <= LW'(in_free_index);
              live_r <= live_r - LIVE_W'(1);
            end
          end
        end
        S_LINK: begin
          // pop: next link arrives from RAM
          head_r <= link_rdata;
          if (live_r != LIVE_MAX) begin
            live_r <= live_r + LIVE_W'(1);
          end
          prod_r  <= PW'(idx_r) * PW'(stride);
          state_r <= S_CALC;
        end
        S_CALC: begin
          out_status_r <= status_r;
          out_live_r   <= live_r;
          out_bytes_r  <= bytes_full[BYTES_W-1:0];
          if (alloc_ok_r) begin
            out_index_r <= FIDX_W'(idx_r);
            out_addr_r  <= pool_base_r + ADDR_W'(prod_r);
          end else begin
            out_index_r <= '0;
            out_addr_r  <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_index   = out_index_r;
  assign out_block_address = out_addr_r;
  assign out_live_count    = out_live_r;
  assign out_bytes_in_use  = out_bytes_r;

`ifndef SYNTHESIS
  // A result strobe only ever follows the result stage
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_CALC))
    else $error("result strobe without result stage");

  // Head is a block index or null
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INIT) |-> (head_r <= LINK_NULL))
    else $error("free list head out of range");

  // A successful pop leaves at least one live block
  a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |=> (live_r != '0))
    else $error("live count zero after allocate");

  // Rejected or free requests report index and address zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(alloc_ok_r)) |-> (out_block_address == '0 && out_block_index == '0))
    else $error("non-allocate result carries an address");

  // Busy stays high from accept to the result strobe
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept) |=> busy)
    else $error("busy dropped right after accept");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the fixed block free list allocator
// A shadow free list predicts every result at the moment a request transfer
// is taken, and each result strobe is checked field by field, in order,
// against the oldest prediction. Directed requests come first, then random
// phases under several pool settings, ending with double frees that close
// the list on itself and push the live count into saturation.
// ----------------------------------------------------------------------------
module tb_top;
  import fbfla_pkg::*;

  localparam int unsigned POOL = POOL_BLOCKS_DEF;

  // One predicted result
  typedef struct packed {
    status_t              status;
    logic [FIDX_W-1:0]    blk_index;
    logic [ADDR_W-1:0]    blk_addr;
    logic [LIVE_W-1:0]    live;
    logic [BYTES_W-1:0]   used_bytes;
  } pool_result_t;

  // Shadow copy of the pool: link table, head, live count and registers
  class free_list_shadow;
    logic [LIVE_W-1:0]  shadow_link [POOL];
    logic [LIVE_W-1:0]  head;
    logic [LIVE_W-1:0]  live_blocks;
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  bsize;
    logic [ALIGN_W-1:0] balign;
    pool_result_t       awaited_results [$];
    int                 errors;

    function new();
      for (int i = 0; i < POOL; i++) shadow_link[i] = LIVE_W'(i + 1);
      head        = '0;
      live_blocks = '0;
      base        = '0;
      bsize       = BLOCK_BYTES_RST;
      balign      = BLOCK_ALIGN_RST;
      errors      = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [APB_DATA_W-1:0] v);
      case (r)
        REG_POOL_BASE:   base   = v[ADDR_W-1:0];
        REG_BLOCK_BYTES: bsize  = v[SIZE_W-1:0];
        REG_BLOCK_ALIGN: balign = v[ALIGN_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request; returns and queues its result
    function pool_result_t take_request(logic kind, logic [SIZE_W-1:0] sz,
                                        logic [ALIGN_W-1:0] al,
                                        logic [FIDX_W-1:0] fi);
      pool_result_t      r;
      logic [63:0]       stride;
      logic [63:0]       addr;
      logic [31:0]       used;
      logic [LIVE_W-1:0] idx;
      r = '0;
      if (kind == KIND_ALLOC) begin
        // size, then alignment, then an empty list
        if (sz != bsize) begin
          r.status = ST_SIZE_ERR;
        end else if (al != balign) begin
          r.status = ST_ALIGN_ERR;
        end else if (head >= POOL) begin
          r.status = ST_POOL_EMPTY;
        end else begin
          idx  = head;
          head = shadow_link[idx];
          if (live_blocks < LIVE_MAX) live_blocks++;
          stride      = 64'(bsize) + 64'(balign);
          addr        = 64'(base) + 64'(idx) * stride;
          r.status    = ST_OK;
          r.blk_index = idx[FIDX_W-1:0];
          r.blk_addr  = addr[ADDR_W-1:0];
        end
      end else begin
        // no check for double frees: the index is pushed again
        if (live_blocks == 0) begin
          r.status = ST_NONE_LIVE;
        end else if (32'(fi) < POOL) begin
          shadow_link[fi] = head;
          head          = LIVE_W'(fi);
          live_blocks--;
          r.status      = ST_OK;
        end else begin
          r.status = ST_OK;
        end
      end
      used         = 32'(live_blocks) * 32'(bsize);
      r.live       = live_blocks;
      r.used_bytes = used[BYTES_W-1:0];
      awaited_results.push_back(r);
      return r;
    endfunction

    task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [FIDX_W-1:0] idx,
                      logic [ADDR_W-1:0] addr, logic [LIVE_W-1:0] live,
                      logic [BYTES_W-1:0] used);
      pool_result_t want;
      if (awaited_results.size() == 0) begin
        flag_mismatch("result transfer with none pending", 64'(status), 64'(0));
        return;
      end
      want = awaited_results.pop_front();
      if (status !== want.status)    flag_mismatch("status", 64'(status), 64'(want.status));
      if (idx !== want.blk_index)    flag_mismatch("block_index", 64'(idx), 64'(want.blk_index));
      if (addr !== want.blk_addr)    flag_mismatch("block_address", 64'(addr), 64'(want.blk_addr));
      if (live !== want.live)        flag_mismatch("live_count", 64'(live), 64'(want.live));
      if (used !== want.used_bytes)  flag_mismatch("bytes_in_use", 64'(used), 64'(want.used_bytes));
    endtask
  endclass

  // Clock and DUT signals
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  busy;
  logic                  in_kind       = KIND_ALLOC;
  logic [SIZE_W-1:0]     in_req_size   = '0;
  logic [ALIGN_W-1:0]    in_req_align  = '0;
  logic [FIDX_W-1:0]     in_free_index = '0;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [FIDX_W-1:0]     out_block_index;
  logic [ADDR_W-1:0]     out_block_address;
  logic [LIVE_W-1:0]     out_live_count;
  logic [BYTES_W-1:0]    out_bytes_in_use;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  free_list_shadow   sb;
  int                idle_pct;
  logic [FIDX_W-1:0] held_blocks [$];

  fixed_block_free_list_allocator dut (
    .clk, .rst_n,
    .start, .busy, .in_kind, .in_req_size, .in_req_align, .in_free_index,
    .out_valid, .out_status, .out_block_index, .out_block_address,
    .out_live_count, .out_bytes_in_use,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result monitor: values seen here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_status, out_block_index, out_block_address,
                      out_live_count, out_bytes_in_use);
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Random sender gap ahead of a request
  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // One request transfer; keeps the list of blocks held by the sender
  task automatic send_request(logic kind, logic [SIZE_W-1:0] sz,
                              logic [ALIGN_W-1:0] al, logic [FIDX_W-1:0] fi);
    pool_result_t r;
    idle_gap();
    start         <= 1'b1;
    in_kind       <= kind;
    in_req_size   <= sz;
    in_req_align  <= al;
    in_free_index <= fi;
    do @(posedge clk); while (busy !== 1'b0);
    r = sb.take_request(kind, sz, al, fi);
    if (kind == KIND_ALLOC && r.status == ST_OK) begin
      held_blocks.push_back(r.blk_index);
    end else if (kind == KIND_FREE && r.status == ST_OK) begin
      for (int k = 0; k < held_blocks.size(); k++) begin
        if (held_blocks[k] == fi) begin
          held_blocks.delete(k);
          break;
        end
      end
    end
  endtask

  // Stop sending and wait for every pending result
  task automatic quiesce();
    start <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [APB_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({r, 3'b000});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pool(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] sz,
                          logic [ALIGN_W-1:0] al);
    write_reg(REG_POOL_BASE, 64'(base));
    write_reg(REG_BLOCK_BYTES, 64'(sz));
    write_reg(REG_BLOCK_ALIGN, 64'(al));
  endtask

  task automatic good_alloc();
    send_request(KIND_ALLOC, sb.bsize, sb.balign, FIDX_W'($urandom));
  endtask

  // Free a held block, or any index when nothing is held
  task automatic free_one();
    logic [FIDX_W-1:0] fi;
    if (held_blocks.size() != 0)
      fi = held_blocks[$urandom_range(held_blocks.size() - 1)];
    else
      fi = FIDX_W'($urandom);
    send_request(KIND_FREE, SIZE_W'($urandom_range(65535)),
                 ALIGN_W'($urandom_range(4096)), fi);
  endtask

  // Allocate with a bad size or a bad alignment (mostly)
  task automatic noisy_alloc();
    if ($urandom_range(1) == 0)
      send_request(KIND_ALLOC, SIZE_W'($urandom_range(65535)),
                   ALIGN_W'($urandom_range(4096)), FIDX_W'($urandom));
    else
      send_request(KIND_ALLOC, sb.bsize, ALIGN_W'($urandom_range(4096)),
                   FIDX_W'($urandom));
  endtask

  // Well-formed traffic with a tide that drifts between filling and draining
  task automatic random_phase(int n);
    int tide;
    tide = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0:       tide = 10;
          1:       tide = 50;
          default: tide = 90;
        endcase
      end
      if ($urandom_range(99) < 8)
        noisy_alloc();
      else if ($urandom_range(99) < tide)
        good_alloc();
      else
        free_one();
      if ($urandom_range(59) == 0) quiesce();
    end
  endtask

  // Allocate until the list runs dry, then hit the empty pool a few times
  task automatic fill_pool();
    for (int g = 0; g < 300 && sb.head < POOL; g++) good_alloc();
    repeat (3) good_alloc();
  endtask

  // Return every held block, then free with nothing allocated
  task automatic drain_pool();
    while (held_blocks.size() != 0) free_one();
    repeat (2) free_one();
  endtask

  task automatic directed_checks();
    // reset settings: 16-byte blocks, alignment 8, base 0
    send_request(KIND_FREE, 16'hFFFF, 13'd4096, 8'd255);
    send_request(KIND_ALLOC, 16'd0, 13'd8, 8'd0);
    send_request(KIND_ALLOC, 16'hFFFF, 13'd4096, 8'hFF);
    send_request(KIND_ALLOC, 16'd16, 13'd0, 8'd0);
    send_request(KIND_ALLOC, 16'd16, 13'd4096, 8'd0);
    send_request(KIND_ALLOC, 16'd16, 13'd8, 8'd0);
    send_request(KIND_ALLOC, 16'd16, 13'd8, 8'hAA);
    send_request(KIND_ALLOC, 16'd16, 13'd8, 8'h55);
    // free lands on the head and comes straight back
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd1);
    send_request(KIND_ALLOC, 16'd16, 13'd8, 8'd0);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd0);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd2);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd1);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd0);
    // largest block and stride, base near the top so addresses wrap
    quiesce();
    set_pool(48'hFFFF_FFFF_FF00, 16'hFFFF, 13'd4096);
    send_request(KIND_ALLOC, 16'hFFFF, 13'd4096, 8'd0);
    send_request(KIND_ALLOC, 16'hFFFF, 13'd4096, 8'd0);
    send_request(KIND_ALLOC, 16'hFFFF, 13'd4096, 8'd0);
    send_request(KIND_ALLOC, 16'hFFFF, 13'd4095, 8'd0);
    send_request(KIND_ALLOC, 16'd16, 13'd4096, 8'd0);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd2);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd0);
    send_request(KIND_FREE, 16'd0, 13'd0, 8'd1);
  endtask

  // Double frees: a self-linked head lets allocates run on to saturation
  task automatic broken_phase();
    logic [FIDX_W-1:0] y;
    for (int g = 0; g < 8 && sb.live_blocks < 2; g++) good_alloc();
    y = (held_blocks.size() != 0) ? held_blocks[0] : '0;
    send_request(KIND_FREE, 16'd0, 13'd0, y);
    send_request(KIND_FREE, 16'hFFFF, 13'd4096, y);
    for (int g = 0; g < 700 && sb.live_blocks != LIVE_MAX; g++) begin
      if ($urandom_range(19) == 0) noisy_alloc();
      else good_alloc();
    end
    repeat (6) good_alloc();
    // frees of arbitrary indices mixed with allocates
    repeat (60) begin
      case ($urandom_range(2))
        0: good_alloc();
        1: send_request(KIND_FREE, SIZE_W'($urandom_range(65535)),
                        ALIGN_W'($urandom_range(4096)), FIDX_W'($urandom));
        default: noisy_alloc();
      endcase
    end
  endtask

  initial begin
    sb       = new();
    idle_pct = 28;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_checks();

    // sender idles often; random pool settings
    quiesce();
    set_pool(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(65535, 1)),
             ALIGN_W'($urandom_range(4096, 1)));
    fill_pool();
    random_phase(100);

    // sender idles more; smallest block and alignment
    quiesce();
    idle_pct = 57;
    set_pool(48'h0, 16'd1, 13'd1);
    random_phase(100);
    drain_pool();

    // back to back; largest settings with the base at the top
    quiesce();
    idle_pct = 0;
    set_pool(48'hFFFF_FFFF_FFFF, 16'hFFFF, 13'd4096);
    random_phase(150);

    quiesce();
    set_pool(ADDR_W'({$urandom, $urandom}), 16'hFFFF, ALIGN_W'($urandom_range(4096, 1)));
    broken_phase();

    quiesce();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[fixed_block_free_list_allocator.f]
sv/fbfla_pkg.sv
sv/fixed_block_free_list_allocator.sv
tb/tb_top.sv
